### rtl/core/bwct_pkg.sv
// shared types and constants for the brace word command tokenizer
package bwct_pkg;

    localparam int DEPTH_BITS_DEF = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_EOC  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_SPACE = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_BRACE = 2'd2,
        MODE_AFTER = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] word_byte;
        logic       is_command_word;
        logic       last;
    } res_t;

    // results produced by one input byte, first in order before second
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } scan_out_t;

endpackage

### rtl/core/brace_word_command_tokenizer_top.sv
// top level of the brace word command tokenizer: input register, scanner, result queue
// Takes one raw byte per request and emits word bytes, end-of-word and end-of-command
// results. A byte is held in the input register, its zero, one or two results
// are computed in a single pass and written to a four-entry result queue, so one byte
// is accepted every cycle while the output side keeps up; a line end that closes a word
// gives two results, which leave the queue one at a time. The queue entries of one byte are
// written together, and a byte is processed only when two queue entries are free.
module brace_word_command_tokenizer_top
    import bwct_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] word_byte, [8] is_command_word, zero above
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       pop;
    logic [2:0] count_reg, count_next;
    logic [2:0] count_after_pop;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    res_t       queue_mem [4];
    res_t       head;
    scan_out_t  scan_out;

    bwct_scan #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (in_byte_reg),
        .scan_out(scan_out)
    );

    assign pop             = m_tvalid & m_tready;
    assign count_after_pop = count_reg - {2'b00, pop};
    assign fire            = in_valid_reg && (count_after_pop <= 3'd2);
    assign s_tready        = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_after_pop;
        if (fire)
        begin
            wr_ptr_next = wr_ptr_reg + scan_out.count;
            count_next  = count_after_pop + {1'b0, scan_out.count};
        end
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && scan_out.count != 2'd0)
            queue_mem[wr_ptr_reg] <= scan_out.first;
        if (fire && scan_out.count == 2'd2)
            queue_mem[wr_ptr_reg + 2'd1] <= scan_out.second;
    end

    assign head     = queue_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {7'd0, head.is_command_word, head.word_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> ({1'b0, count_after_pop} + {2'b00, scan_out.count}) <= 4'd4)
        else $error("result queue overflow");
    a_eoc_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_EOC |-> m_tlast)
        else $error("end of command not marked last");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 3'd4 |-> (wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/bwct_scan.sv
// tokenizer state and per-byte result generation
module bwct_scan
    import bwct_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] byte_in,
    output scan_out_t  scan_out
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

    mode_t                 mode_reg, mode_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  param_reg, param_next;
    logic                  line_reg, line_next;

    function automatic res_t mk_res(kind_t k, logic [7:0] b, logic c);
        res_t r;
        r.kind            = k;
        r.word_byte       = b;
        r.is_command_word = c;
        r.last            = 1'b0;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SPACE;
            depth_reg <= '0;
            param_reg <= 1'b0;
            line_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            param_reg <= param_next;
            line_reg  <= line_next;
        end
    end

    always_comb
    begin
        logic cmd;
        res_t r0;
        res_t r1;
        logic [1:0] n;
        cmd        = ~param_reg;
        r0         = mk_res(KIND_BYTE, 8'd0, 1'b0);
        r1         = mk_res(KIND_BYTE, 8'd0, 1'b0);
        n          = 2'd0;
        mode_next  = mode_reg;
        depth_next = depth_reg;
        param_next = param_reg;
        line_next  = line_reg;
        if (byte_in == CH_CR)
        begin
            n = 2'd0;
        end
        else if (byte_in == CH_LF)
        begin
            if (line_reg)
            begin
                line_next = 1'b0;
                if (mode_reg != MODE_BRACE)
                begin
                    if (mode_reg == MODE_PLAIN || mode_reg == MODE_AFTER)
                    begin
                        r0 = mk_res(KIND_EOW, 8'd0, cmd);
                        r1 = mk_res(KIND_EOC, 8'd0, 1'b0);
                        n  = 2'd2;
                    end
                    else
                    begin
                        r0 = mk_res(KIND_EOC, 8'd0, 1'b0);
                        n  = 2'd1;
                    end
                    mode_next  = MODE_SPACE;
                    param_next = 1'b0;
                    depth_next = '0;
                end
            end
        end
        else
        begin
            line_next = 1'b1;
            case (mode_reg)
                MODE_SPACE:
                begin
                    if (byte_in == CH_OPEN)
                    begin
                        mode_next  = MODE_BRACE;
                        depth_next = DEPTH_ONE;
                    end
                    else if (byte_in != CH_SPACE && byte_in != CH_CLOSE)
                    begin
                        r0        = mk_res(KIND_BYTE, byte_in, cmd);
                        n         = 2'd1;
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_PLAIN, MODE_AFTER:
                begin
                    if (byte_in == CH_SPACE)
                    begin
                        r0         = mk_res(KIND_EOW, 8'd0, cmd);
                        n          = 2'd1;
                        param_next = 1'b1;
                        mode_next  = MODE_SPACE;
                    end
                    else if (mode_reg == MODE_PLAIN)
                    begin
                        r0 = mk_res(KIND_BYTE, byte_in, cmd);
                        n  = 2'd1;
                    end
                end
                default:
                begin
                    // inside a brace group; the outer closing brace ends it
                    if (byte_in == CH_CLOSE && depth_reg <= DEPTH_ONE)
                    begin
                        depth_next = '0;
                        mode_next  = MODE_AFTER;
                    end
                    else
                    begin
                        if (byte_in == CH_OPEN)
                        begin
                            if (depth_reg != DEPTH_MAX)
                                depth_next = depth_reg + DEPTH_ONE;
                        end
                        else if (byte_in == CH_CLOSE)
                        begin
                            depth_next = depth_reg - DEPTH_ONE;
                        end
                        r0 = mk_res(KIND_BYTE, byte_in, cmd);
                        n  = 2'd1;
                    end
                end
            endcase
        end
        if (n == 2'd2)
            r1.last = 1'b1;
        else
            r0.last = 1'b1;
        scan_out.count  = n;
        scan_out.first  = r0;
        scan_out.second = r1;
    end

`ifndef SYNTH
    a_depth_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_BRACE |-> depth_reg == '0)
        else $error("depth nonzero outside a brace group");
    a_depth_group: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_BRACE |-> depth_reg != '0)
        else $error("depth zero inside a brace group");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire && scan_out.count == 2'd2 |->
            scan_out.first.kind == KIND_EOW && scan_out.second.kind == KIND_EOC)
        else $error("two results not end of word then end of command");
`endif

endmodule
